// File: sv/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Widths, constants and register codes shared by the Sobel magnitude unit.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned PIX_W        = 8;
  localparam int unsigned CFG_W        = 11;
  localparam int unsigned EDGE_W       = 8;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_HEIGHT    = 1024;
  localparam int unsigned MIN_DIM       = 3;
  localparam int unsigned ROW_W         = $clog2(MAX_HEIGHT);
  localparam int unsigned HW            = $clog2(MAX_HEIGHT + 1);

  localparam int unsigned WIDTH_RESET  = 700;
  localparam int unsigned HEIGHT_RESET = 500;

  // gradient path: |g| <= 4*255 -> 11 bit signed, g^2 < 2^20, sum < 2^21
  localparam int unsigned SUM4_W   = 10;
  localparam int unsigned GRAD_W   = 11;
  localparam int unsigned SQ_W     = 20;
  localparam int unsigned SUM_W    = 21;
  localparam int unsigned ROOT_W   = 11;
  localparam int unsigned SQ_STEPS = (SUM_W + 1) / 2;

  // floor(m*255/1443) as floor(m * 255 * ceil(2^30/1443) / 2^30), exact for m <= 1442
  localparam int unsigned MAG_FULL_SCALE = 1443;
  localparam int unsigned OUT_FULL_SCALE = 255;
  localparam int unsigned SCALE_SHIFT    = 30;
  localparam int unsigned SCALE_RECIP    =
    ((32'd1 << SCALE_SHIFT) + MAG_FULL_SCALE - 1) / MAG_FULL_SCALE;
  localparam int unsigned SCALE_MULT     = OUT_FULL_SCALE * SCALE_RECIP;
  localparam int unsigned MULT_W         = 28;
  localparam int unsigned PROD_W         = ROOT_W + MULT_W;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CFG_W-1:0]  cfg_data_t;
  typedef logic [EDGE_W-1:0] edge_t;

endpackage

// File: sv/sem_in_if.sv
// ----------------------------------------------------------------------------
// sem_in_if
// Pixel stream channel: valid/ready with one pixel per beat.
// ----------------------------------------------------------------------------
interface sem_in_if;
  import sem_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// File: sv/sem_out_if.sv
// ----------------------------------------------------------------------------
// sem_out_if
// Result channel: valid/ready with one edge magnitude per beat.
// ----------------------------------------------------------------------------
interface sem_out_if;
  import sem_pkg::*;

  logic  valid;
  logic  ready;
  edge_t edge_value;
  logic  frame_last;

  modport source (output valid, output edge_value, output frame_last, input ready);
  modport sink   (input valid, input edge_value, input frame_last, output ready);
endinterface

// File: sv/sobel_edge_magnitude_unit.sv
// Accept to out valid: stage-1, gradient, square, sum, square root and output registers.
// Throughput: one pixel per cycle; the whole pipeline advances together and halts only
// while the output register holds a beat that the sink has not taken.
// Rate is set by the line memories (one read and one write per cycle) and the
// 11-stage square root pipeline. Reset clears counters, window and valid bits at once;
// line memories are not cleared and hold stale rows until the first two rows pass.
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_unit
// 3x3 Sobel gradient magnitude on a raster pixel stream, scaled to 0..254.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_unit #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  sem_in_if.sink             in_bus,
  sem_out_if.source          out_bus,
  input  logic               cfg_we,
  input  sem_pkg::cfg_reg_t  cfg_idx,
  input  sem_pkg::cfg_data_t cfg_wdata
);
  import sem_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH);      // column counter / memory address
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);  // effective width

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_data_t width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(WIDTH_RESET);
      height_r <= CFG_W'(HEIGHT_RESET);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp to the legal frame size
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (width_r < CFG_W'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r < CFG_W'(MIN_DIM)) begin
      h_eff = HW'(MIN_DIM);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_r);
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: every stage moves when the output register can take a beat
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic adv, in_go;

  assign adv          = !out_valid_r || out_bus.ready;
  assign in_bus.ready = adv;
  assign in_go        = in_bus.valid && adv;

  // --------------------------------------------------------------------------
  // Raster position
  // --------------------------------------------------------------------------
  logic [CW-1:0]    col_cnt_r;
  logic [ROW_W-1:0] row_cnt_r;
  logic [WW:0]      col_p1;
  logic [HW-1:0]    row_p1;
  logic             row_end, frame_end, interior;

  assign col_p1    = (WW+1)'(col_cnt_r) + (WW+1)'(1);
  assign row_p1    = HW'(row_cnt_r) + HW'(1);
  assign row_end   = col_p1 >= (WW+1)'(w_eff);
  assign frame_end = row_end && (row_p1 >= h_eff);
  assign interior  = (row_cnt_r >= ROW_W'(2)) && (col_cnt_r >= CW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_go) begin
      if (row_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= frame_end ? '0 : ROW_W'(row_p1);
      end else begin
        col_cnt_r <= CW'(col_p1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Line memories: top_mem holds row r-2, mid_mem row r-1, one entry per column.
  // Read at accept, written back from the stage-1 registers as they advance, rows moved up.
  // Neighbouring beats always address different columns, so no forwarding.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] top_mem [MAX_WIDTH];
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];

  logic             s1_valid_r;
  logic             s1_int_r, s1_last_r;
  logic [CW-1:0]    s1_col_r;
  pix_t             s1_pix_r;
  pix_t             top_rd_r, mid_rd_r;
  logic             s1_go;

  assign s1_go = adv && s1_valid_r;

  always_ff @(posedge clk) begin
    if (in_go) begin
      top_rd_r <= top_mem[col_cnt_r];
      mid_rd_r <= mid_mem[col_cnt_r];
      s1_pix_r <= in_bus.pixel;
      s1_col_r <= col_cnt_r;
      s1_int_r <= interior;
      s1_last_r <= frame_end;
    end
    if (s1_go) begin
      top_mem[s1_col_r] <= mid_rd_r;
      mid_mem[s1_col_r] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_go;
    end
  end

  // --------------------------------------------------------------------------
  // 3x3 window: left column (c-2) and centre column (c-1); right column is
  // the memory read plus the new pixel.
  // --------------------------------------------------------------------------
  pix_t lt_r, lm_r, lb_r, ct_r, cm_r, cb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= '0; lm_r <= '0; lb_r <= '0;
      ct_r <= '0; cm_r <= '0; cb_r <= '0;
    end else if (s1_go) begin
      lt_r <= ct_r; lm_r <= cm_r; lb_r <= cb_r;
      ct_r <= top_rd_r; cm_r <= mid_rd_r; cb_r <= s1_pix_r;
    end
  end

  // gx = left(1,2,1) - right(1,2,1), gy = top(1,2,1) - bottom(1,2,1)
  logic [SUM4_W-1:0]        sx_a, sx_b, sy_a, sy_b;
  logic signed [GRAD_W-1:0] gx, gy;

  assign sx_a = SUM4_W'(lt_r) + {1'b0, lm_r, 1'b0} + SUM4_W'(lb_r);
  assign sx_b = SUM4_W'(top_rd_r) + {1'b0, mid_rd_r, 1'b0} + SUM4_W'(s1_pix_r);
  assign sy_a = SUM4_W'(lt_r) + {1'b0, ct_r, 1'b0} + SUM4_W'(top_rd_r);
  assign sy_b = SUM4_W'(lb_r) + {1'b0, cb_r, 1'b0} + SUM4_W'(s1_pix_r);
  assign gx   = $signed({1'b0, sx_a}) - $signed({1'b0, sx_b});
  assign gy   = $signed({1'b0, sy_a}) - $signed({1'b0, sy_b});

  // --------------------------------------------------------------------------
  // Gradient, square and sum stages (only interior pixels carry a valid bit)
  // --------------------------------------------------------------------------
  logic                     vld2_r, vld3_r, vld4_r;
  logic                     last2_r, last3_r, last4_r;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
  logic [SQ_W-1:0]          sqx_r, sqy_r;
  logic [SUM_W-1:0]         sum_r;

  assign gx_sq = gx_r * gx_r;
  assign gy_sq = gy_r * gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= s1_valid_r && s1_int_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gx_r    <= gx;
      gy_r    <= gy;
      last2_r <= s1_last_r;
      sqx_r   <= gx_sq[SQ_W-1:0];
      sqy_r   <= gy_sq[SQ_W-1:0];
      last3_r <= last2_r;
      sum_r   <= SUM_W'(sqx_r) + SUM_W'(sqy_r);
      last4_r <= last3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Floor square root: one result bit per stage, bit weight 4^(SQ_STEPS-1-i)
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]    rem_r  [SQ_STEPS];
  logic [SUM_W-1:0]    root_r [SQ_STEPS];
  logic [SQ_STEPS-1:0] sq_vld_r;
  logic [SQ_STEPS-1:0] sq_last_r;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [SUM_W:0] BIT = (SUM_W+1)'(1) << (2 * (SQ_STEPS - 1 - i));

    logic [SUM_W-1:0] rem_in, root_in, rem_o, root_o;
    logic             vld_in, last_in;
    logic [SUM_W:0]   trial;

    if (i == 0) begin : g_first
      assign rem_in  = sum_r;
      assign root_in = '0;
      assign vld_in  = vld4_r;
      assign last_in = last4_r;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign vld_in  = sq_vld_r[i-1];
      assign last_in = sq_last_r[i-1];
    end

    assign trial = (SUM_W+1)'(root_in) + BIT;

    always_comb begin
      if ((SUM_W+1)'(rem_in) >= trial) begin
        rem_o  = rem_in - trial[SUM_W-1:0];
        root_o = (root_in >> 1) + BIT[SUM_W-1:0];
      end else begin
        rem_o  = rem_in;
        root_o = root_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i] <= 1'b0;
      end else if (adv) begin
        sq_vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]     <= rem_o;
        root_r[i]    <= root_o;
        sq_last_r[i] <= last_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale 0..1442 to 0..254 by reciprocal multiply, into the output register
  // --------------------------------------------------------------------------
  logic [ROOT_W-1:0] mag;
  logic [PROD_W-1:0] prod;
  edge_t             edge_r;
  logic              last_r;

  assign mag  = root_r[SQ_STEPS-1][ROOT_W-1:0];
  assign prod = PROD_W'(mag) * PROD_W'(SCALE_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sq_vld_r[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      edge_r <= prod[SCALE_SHIFT +: EDGE_W];
      last_r <= sq_last_r[SQ_STEPS-1];
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.edge_value = edge_r;
  assign out_bus.frame_last = last_r;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_mem_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_go && s1_go) |-> (col_cnt_r != s1_col_r))
    else $error("line memory read and write hit the same column");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_go && frame_end) |=> (col_cnt_r == '0 && row_cnt_r == '0))
    else $error("raster position did not wrap at end of frame");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({s1_valid_r, vld2_r, vld3_r, vld4_r, sq_vld_r, out_valid_r}))
    else $error("pipeline moved while stalled");

endmodule
